// ----- src/orup_pkg.sv -----
// Shared types and constants for the occupancy ray update block.
package orup_pkg;

  localparam int COORD_BITS = 16;
  localparam int CELL_BITS  = 16;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 4;
  localparam int STEP_BITS  = 16;
  localparam int BOUND_BITS = 10;
  localparam int LOW_BITS   = 11;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CELL_BITS-1:0] CELL_MAX  = {CELL_BITS{1'b1}};
  localparam logic [CELL_BITS-1:0] CELL_HALF = {1'b1, {(CELL_BITS-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_STEP = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAISE_STEP = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS       = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS       = 8'd3;

  // Item kinds.
  localparam logic KIND_RAY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [CELL_BITS-1:0] cell_value;
    logic [LOW_BITS-1:0]  cells_lowered;
    logic                 cell_raised;
    logic                 out_of_grid;
  } out_item_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic                         sx_neg;
    logic                         sy_neg;
    logic                         xmajor;
    logic [DELTA_BITS-1:0]        dmaj;
    logic [DELTA_BITS-1:0]        dmin;
    logic signed [ERR_BITS-1:0]   p0;
  } job_t;

endpackage

// ----- src/orup_front.sv -----
// Front end: accepts items, works out ray direction and Bresenham setup.
module orup_front import orup_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t item_i,
  input  logic     busy_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  logic     stage_v_q, stage_v_d;
  in_item_t stage_q;
  logic     accept;

  logic signed [DELTA_BITS-1:0] dxs, dys;
  logic [DELTA_BITS-1:0]        adx, ady;
  logic                         xmaj;

  assign full   = busy_i || (stage_v_q && !job_ready_i);
  assign accept = push && !full;

  // Staging register for one accepted beat.
  always_comb begin
    stage_v_d = stage_v_q;
    if (accept) begin
      stage_v_d = 1'b1;
    end else if (stage_v_q && job_ready_i) begin
      stage_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= item_i;
    end
  end

  // Deltas, step signs and the initial decision term.
  always_comb begin
    dxs  = {stage_q.end_x[COORD_BITS-1], stage_q.end_x}
         - {stage_q.start_x[COORD_BITS-1], stage_q.start_x};
    dys  = {stage_q.end_y[COORD_BITS-1], stage_q.end_y}
         - {stage_q.start_y[COORD_BITS-1], stage_q.start_y};
    adx  = dxs[DELTA_BITS-1] ? DELTA_BITS'(-dxs) : DELTA_BITS'(dxs);
    ady  = dys[DELTA_BITS-1] ? DELTA_BITS'(-dys) : DELTA_BITS'(dys);
    xmaj = adx > ady;
    job_o.kind   = stage_q.kind;
    job_o.x      = stage_q.start_x;
    job_o.y      = stage_q.start_y;
    job_o.ex     = stage_q.end_x;
    job_o.ey     = stage_q.end_y;
    job_o.sx_neg = dxs[DELTA_BITS-1] || (dxs == '0);
    job_o.sy_neg = dys[DELTA_BITS-1] || (dys == '0);
    job_o.xmajor = xmaj;
    job_o.dmaj   = xmaj ? adx : ady;
    job_o.dmin   = xmaj ? ady : adx;
    job_o.p0     = $signed({2'b00, job_o.dmin, 1'b0}) - $signed({3'b000, job_o.dmaj});
  end

  assign job_valid_o = stage_v_q;

endmodule

// ----- src/orup_queue.sv -----
// Two-entry queue of classified jobs between the front and the back.
module orup_queue import orup_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  input  logic rd_pop_i,
  output job_t rd_job_o
);

  job_t       slot_q [2];
  logic       head_q, head_d, tail_q, tail_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_pop_i && rd_valid_o;
  assign rd_job_o = slot_q[head_q];

  // Pointer and count update.
  always_comb begin
    head_d = rd ? !head_q : head_q;
    tail_d = wr ? !tail_q : tail_q;
    cnt_d  = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      tail_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      slot_q[tail_q] <= wr_job_i;
    end
  end

endmodule

// ----- src/orup_back.sv -----
// Back end: clears the grid, walks rays with read-modify-write, serves reads.
module orup_back import orup_pkg::*; #(
  parameter int GRID_COLS = 512,
  parameter int GRID_ROWS = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_pop_o,
  input  job_t                  job_i,
  input  logic [STEP_BITS-1:0]  lower_step_i,
  input  logic [STEP_BITS-1:0]  raise_step_i,
  input  logic [BOUND_BITS-1:0] cols_i,
  input  logic [BOUND_BITS-1:0] rows_i,
  output logic                  busy_o,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             result_o
);

  localparam int DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(GRID_COLS);
  localparam int YW     = $clog2(GRID_ROWS);
  localparam int BW     = 14;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WALK  = 4'd2;
  localparam logic [3:0] ST_LWR   = 4'd3;
  localparam logic [3:0] ST_FIN   = 4'd4;
  localparam logic [3:0] ST_RAISE = 4'd5;
  localparam logic [3:0] ST_RD    = 4'd6;
  localparam logic [3:0] ST_RDW   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d, pend_q, pend_d;
  job_t        job_q, job_d;
  logic signed [ERR_BITS-1:0] p_q, p_d;
  logic        have_q, have_d;
  logic [LOW_BITS-1:0] low_q, low_d;
  logic        raised_q, raised_d, oog_q, oog_d;
  logic [CELL_BITS-1:0] val_q, val_d;
  logic        res_v_q, res_v_d;
  out_item_t   res_q, res_d;

  logic [CELL_BITS-1:0] mem [DEPTH];
  logic [CELL_BITS-1:0] rd_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa, mem_ra;
  logic [CELL_BITS-1:0] mem_wd;

  logic [BW-1:0]        effc, effr;
  logic                 kept, last, p_ge;
  logic [ADDR_W-1:0]    cur_addr;
  logic signed [COORD_BITS-1:0] x_n, y_n;
  logic signed [ERR_BITS-1:0]   p_n, two_min, two_maj;
  logic [CELL_BITS-1:0]  lowered_val, raised_val;
  logic [CELL_BITS:0]    sum;

  // Grid bounds in use, clipped to the grid size.
  assign effc = (BW'(cols_i) > BW'(GRID_COLS)) ? BW'(GRID_COLS) : BW'(cols_i);
  assign effr = (BW'(rows_i) > BW'(GRID_ROWS)) ? BW'(GRID_ROWS) : BW'(rows_i);

  // Current cell classification and address.
  assign kept = !job_q.x[COORD_BITS-1] && !job_q.y[COORD_BITS-1]
             && (COORD_BITS'(job_q.x) < COORD_BITS'(effc))
             && (COORD_BITS'(job_q.y) < COORD_BITS'(effr));
  assign cur_addr = ADDR_W'(job_q.y[YW-1:0] * ADDR_W'(GRID_COLS)) + ADDR_W'(job_q.x[XW-1:0]);
  assign last = job_q.xmajor ? (job_q.x == job_q.ex) : (job_q.y == job_q.ey);

  // One Bresenham step.
  always_comb begin
    two_min = $signed({2'b00, job_q.dmin, 1'b0});
    two_maj = $signed({2'b00, job_q.dmaj, 1'b0});
    p_ge    = !p_q[ERR_BITS-1];
    p_n     = p_q + two_min - (p_ge ? two_maj : '0);
    x_n     = job_q.x;
    y_n     = job_q.y;
    if (job_q.xmajor || p_ge) begin
      x_n = job_q.x + (job_q.sx_neg ? -16'sd1 : 16'sd1);
    end
    if (!job_q.xmajor || p_ge) begin
      y_n = job_q.y + (job_q.sy_neg ? -16'sd1 : 16'sd1);
    end
  end

  // Saturating cell updates from the registered read data.
  assign lowered_val = (lower_step_i > rd_q) ? '0 : rd_q - lower_step_i;
  assign sum         = {1'b0, rd_q} + {1'b0, raise_step_i};
  assign raised_val  = sum[CELL_BITS] ? CELL_MAX : sum[CELL_BITS-1:0];

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pend_d   = pend_q;
    job_d    = job_q;
    p_d      = p_q;
    have_d   = have_q;
    low_d    = low_q;
    raised_d = raised_q;
    oog_d    = oog_q;
    val_d    = val_q;
    res_v_d  = res_v_q && !pop;
    res_d    = res_q;
    job_pop_o = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = pend_q;
    mem_wd   = lowered_val;
    mem_ra   = (state_q == ST_RD) ? cur_addr : pend_q;
    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = CELL_HALF;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          p_d       = job_i.p0;
          have_d    = 1'b0;
          low_d     = '0;
          raised_d  = 1'b0;
          oog_d     = 1'b0;
          val_d     = '0;
          state_d   = (job_i.kind == KIND_READ) ? ST_RD : ST_WALK;
        end
      end
      ST_WALK: begin
        if (kept && have_q) begin
          state_d = ST_LWR;
        end else begin
          if (kept) begin
            pend_d = cur_addr;
            have_d = 1'b1;
          end
          if (last) begin
            state_d = ST_FIN;
          end else begin
            job_d.x = x_n;
            job_d.y = y_n;
            p_d     = p_n;
          end
        end
      end
      ST_LWR: begin
        mem_we = 1'b1;
        low_d  = low_q + 1'b1;
        pend_d = cur_addr;
        if (last) begin
          state_d = ST_FIN;
        end else begin
          job_d.x = x_n;
          job_d.y = y_n;
          p_d     = p_n;
          state_d = ST_WALK;
        end
      end
      ST_FIN: begin
        state_d = have_q ? ST_RAISE : ST_DONE;
      end
      ST_RAISE: begin
        mem_we   = 1'b1;
        mem_wd   = raised_val;
        raised_d = 1'b1;
        state_d  = ST_DONE;
      end
      ST_RD: begin
        if (kept) begin
          state_d = ST_RDW;
        end else begin
          oog_d   = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_RDW: begin
        val_d   = rd_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_v_q || pop) begin
          res_v_d = 1'b1;
          res_d.cell_value    = val_q;
          res_d.cells_lowered = low_q;
          res_d.cell_raised   = raised_q;
          res_d.out_of_grid   = oog_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      res_v_q <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      res_v_q <= res_v_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    job_q    <= job_d;
    p_q      <= p_d;
    low_q    <= low_d;
    raised_q <= raised_d;
    oog_q    <= oog_d;
    val_q    <= val_d;
    res_q    <= res_d;
  end

  // Grid memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  assign busy_o   = state_q == ST_CLR;
  assign empty    = !res_v_q;
  assign result_o = res_q;

endmodule

// ----- src/occupancy_ray_update.sv -----
// Top level of the occupancy grid ray update block.
//
// Items enter through a queue-like port: a beat is taken when push is high
// and full is low. A ray item walks the Bresenham line between its start and
// end cells, lowers every in-grid cell but the last and raises the last one;
// a read item returns one cell. Each item gives one result, presented while
// empty is low and taken when pop is high.
// A ray walks each cell on its line (in grid or not) as one step, with an
// extra read-modify-write step on the grid memory for every lowered cell,
// then finishes and raises the last kept cell; a ray between extreme
// coordinates walks up to about 65536 cells. A read of an in-grid cell
// passes a read and a read-wait state before its result is registered.
// Items are handled one at a time by the back end; a front stage and a
// two-entry job queue take further items meanwhile.
// After reset the grid is swept to one half, one cell per cycle, over all
// GRID_COLS * GRID_ROWS cells; full stays high during the sweep.
// Configuration writes are taken at any time. If the receiver does not pop,
// the result register holds and the back end waits with the next result.
module occupancy_ray_update import orup_pkg::*; #(
  parameter int GRID_COLS = 512,
  parameter int GRID_ROWS = 512
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  in_item_t                 item_i,
  output logic                     empty,
  input  logic                     pop,
  output out_item_t                result_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic [STEP_BITS-1:0]  lower_q, raise_q;
  logic [BOUND_BITS-1:0] cols_q, rows_q;
  logic                  busy;
  logic                  fj_valid, fj_ready, bj_valid, bj_pop;
  job_t                  fj, bj;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 16'd655;
      raise_q <= 16'd6554;
      cols_q  <= 10'd400;
      rows_q  <= 10'd400;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOWER_STEP: lower_q <= cfg_data_i;
        CFG_RAISE_STEP: raise_q <= cfg_data_i;
        CFG_COLS:       cols_q  <= cfg_data_i[BOUND_BITS-1:0];
        CFG_ROWS:       rows_q  <= cfg_data_i[BOUND_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  orup_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .busy_i      (busy),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj)
  );

  orup_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fj_valid),
    .wr_ready_o (fj_ready),
    .wr_job_i   (fj),
    .rd_valid_o (bj_valid),
    .rd_pop_i   (bj_pop),
    .rd_job_o   (bj)
  );

  orup_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (bj_valid),
    .job_pop_o    (bj_pop),
    .job_i        (bj),
    .lower_step_i (lower_q),
    .raise_step_i (raise_q),
    .cols_i       (cols_q),
    .rows_i       (rows_q),
    .busy_o       (busy),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule

// ----- verif/occupancy_ray_update_test.sv -----
// Self-checking testbench for the occupancy grid ray update block.
module occupancy_ray_update_test;
  import orup_pkg::*;

  localparam int GCOLS = 512;
  localparam int GROWS = 512;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 1200;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  in_item_t item_i;
  logic empty;
  logic pop;
  out_item_t result_o;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  occupancy_ray_update #(.GRID_COLS(GCOLS), .GRID_ROWS(GROWS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the grid and the registers.
  logic [CELL_BITS-1:0] occ_cells [0:GCOLS*GROWS-1];
  logic [STEP_BITS-1:0] shadow_lower;
  logic [STEP_BITS-1:0] shadow_raise;
  logic [BOUND_BITS-1:0] shadow_cols;
  logic [BOUND_BITS-1:0] shadow_rows;

  out_item_t pending_results[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  longint cycle_count;

  // Directed stimulus; lit marks rows whose result is typed in.
  typedef struct packed {
    logic kind;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    logic lit;
    out_item_t want;
  } drow_t;

  localparam int NDIR = 17;
  localparam drow_t DIRECTED [NDIR] = '{
    '{KIND_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'd32768, 11'd0, 1'b0, 1'b0}},
    '{KIND_READ, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'd0, 11'd0, 1'b0, 1'b1}},
    '{KIND_READ, 16'sd400, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'd0, 11'd0, 1'b0, 1'b1}},
    '{KIND_READ, 16'h7fff, 16'h8000, 16'hffff, 16'h7fff, 1'b1, '{16'd0, 11'd0, 1'b0, 1'b1}},
    '{KIND_RAY, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1, '{16'd0, 11'd0, 1'b1, 1'b0}},
    '{KIND_READ, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 1'b1, '{16'd39322, 11'd0, 1'b0, 1'b0}},
    '{KIND_RAY, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 1'b1, '{16'd0, 11'd3, 1'b1, 1'b0}},
    '{KIND_RAY, 16'sd2, 16'sd2, 16'sd4, 16'sd4, 1'b0, '0},
    '{KIND_RAY, -16'sd5, -16'sd5, -16'sd1, -16'sd1, 1'b1, '{16'd0, 11'd0, 1'b0, 1'b0}},
    '{KIND_RAY, 16'sd10, 16'sd10, 16'sd10, 16'sd500, 1'b1, '{16'd0, 11'd389, 1'b1, 1'b0}},
    '{KIND_RAY, 16'h8000, 16'h8000, 16'h8008, 16'h8003, 1'b1, '{16'd0, 11'd0, 1'b0, 1'b0}},
    '{KIND_RAY, 16'h7fff, 16'h7fff, 16'h7ff8, 16'h7fff, 1'b1, '{16'd0, 11'd0, 1'b0, 1'b0}},
    '{KIND_RAY, 16'sd399, 16'sd399, 16'sd0, 16'sd0, 1'b1, '{16'd0, 11'd399, 1'b1, 1'b0}},
    '{KIND_RAY, 16'sd3, 16'sd0, 16'sd0, 16'sd1, 1'b0, '0},
    '{KIND_RAY, 16'sd1, 16'sd7, 16'sd0, 16'sd0, 1'b0, '0},
    '{KIND_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
    '{KIND_READ, 16'sd1, 16'sd0, 16'hffff, 16'hffff, 1'b0, '0}
  };

  // Walks one item over the shadow grid and returns its result.
  function automatic out_item_t trace_cells(in_item_t it);
    longint x, y, ex, ey, dx, dy, sx, sy, p, cols, rows;
    bit have, xmaj, last;
    int pend;
    out_item_t r;
    int v;
    r = '0;
    have = 0;
    pend = 0;
    cols = (shadow_cols > GCOLS) ? GCOLS : shadow_cols;
    rows = (shadow_rows > GROWS) ? GROWS : shadow_rows;
    x = it.start_x;
    y = it.start_y;
    if (it.kind == KIND_READ) begin
      if (x >= 0 && x < cols && y >= 0 && y < rows) r.cell_value = occ_cells[y*GCOLS + x];
      else r.out_of_grid = 1'b1;
      return r;
    end
    ex = it.end_x;
    ey = it.end_y;
    dx = (ex > x) ? ex - x : x - ex;
    dy = (ey > y) ? ey - y : y - ey;
    sx = (ex > x) ? 1 : -1;
    sy = (ey > y) ? 1 : -1;
    xmaj = dx > dy;
    p = xmaj ? 2*dy - dx : 2*dx - dy;
    forever begin
      last = xmaj ? (x == ex) : (y == ey);
      if (x >= 0 && x < cols && y >= 0 && y < rows) begin
        // A newly kept cell frees the one kept before it.
        if (have) begin
          v = occ_cells[pend];
          occ_cells[pend] = (shadow_lower > v) ? '0 : CELL_BITS'(v - shadow_lower);
          r.cells_lowered = r.cells_lowered + 1'b1;
        end
        pend = int'(y*GCOLS + x);
        have = 1;
      end
      if (last) break;
      if (xmaj) begin
        if (p >= 0) begin
          y += sy;
          p -= 2*dx;
        end
        x += sx;
        p += 2*dy;
      end else begin
        if (p >= 0) begin
          x += sx;
          p -= 2*dy;
        end
        y += sy;
        p += 2*dx;
      end
    end
    if (have) begin
      v = occ_cells[pend] + shadow_raise;
      occ_cells[pend] = (v > CELL_MAX) ? CELL_MAX : CELL_BITS'(v);
      r.cell_raised = 1'b1;
    end
    return r;
  endfunction

  // Offers one beat and records its expected result once taken.
  task automatic offer_beat(in_item_t it, bit use_lit, out_item_t lit_val);
    out_item_t got;
    push <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    got = trace_cells(it);
    pending_results.push_back(use_lit ? lit_val : got);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Waits until the block has drained, then lets the walk settle.
  task automatic drain_block();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LOWER_STEP: shadow_lower = val;
      CFG_RAISE_STEP: shadow_raise = val;
      CFG_COLS:       shadow_cols = val[BOUND_BITS-1:0];
      CFG_ROWS:       shadow_rows = val[BOUND_BITS-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] clamp_coord(longint c);
    if (c > 32767) return 16'h7fff;
    if (c < -32768) return 16'h8000;
    return c[15:0];
  endfunction

  // Coordinate mostly near the origin, sometimes across the whole bound.
  function automatic longint pick_coord(longint bound);
    if ($urandom_range(99) < 70) return longint'($urandom_range(44)) - 4;
    return longint'($urandom_range(bound + 16)) - 8;
  endfunction

  // Random item: mostly short rays in the busy corner, some reads and noise.
  function automatic in_item_t random_item();
    in_item_t it;
    longint cols, rows, x, y, len;
    int pick;
    cols = (shadow_cols > GCOLS) ? GCOLS : shadow_cols;
    rows = (shadow_rows > GROWS) ? GROWS : shadow_rows;
    pick = $urandom_range(99);
    it.kind = (pick < 25) ? KIND_READ : KIND_RAY;
    if (pick >= 92) begin
      x = longint'($signed(16'($urandom)));
      y = longint'($signed(16'($urandom)));
    end else begin
      x = pick_coord(cols);
      y = pick_coord(rows);
    end
    len = ($urandom_range(49) == 0) ? 530 : 20;
    it.start_x = clamp_coord(x);
    it.start_y = clamp_coord(y);
    it.end_x = clamp_coord(x + longint'($urandom_range(2*len)) - len);
    it.end_y = clamp_coord(y + longint'($urandom_range(2*len)) - len);
    if (it.kind == KIND_READ && $urandom_range(1)) begin
      it.end_x = 16'($urandom);
      it.end_y = 16'($urandom);
    end
    return it;
  endfunction

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle count and the run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request) begin
      pop <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      hold_request <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each popped beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", result_o);
      end else begin
        want = pending_results.pop_front();
        if (result_o.cell_value !== want.cell_value ||
            result_o.cells_lowered !== want.cells_lowered ||
            result_o.cell_raised !== want.cell_raised ||
            result_o.out_of_grid !== want.out_of_grid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", want, result_o);
        end
      end
    end
  end

  // Main sequence: directed table, then random phases over register settings.
  initial begin
    logic [15:0] cfg_sets [8][4];
    in_item_t it;
    int phase;
    cycle_count = 0;
    mismatches = 0;
    hold_request = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push = 1'b0;
    pop = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    for (int i = 0; i < GCOLS*GROWS; i++) occ_cells[i] = CELL_HALF;
    shadow_lower = 655;
    shadow_raise = 6554;
    shadow_cols = 400;
    shadow_rows = 400;
    cfg_sets = '{'{16'd0, 16'd65535, 16'd48, 16'd48}, '{16'd65535, 16'd0, 16'd48, 16'd40},
                 '{16'd1200, 16'd3000, 16'd1, 16'd512}, '{16'd300, 16'd9000, 16'd0, 16'd30},
                 '{16'd20000, 16'd20000, 16'd1023, 16'd1023}, '{16'd5, 16'd100, 16'd512, 16'd3},
                 '{16'd900, 16'd7000, 16'd40, 16'd48}, '{16'd655, 16'd6554, 16'd400, 16'd400}};
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NDIR; i++) begin
      it.kind = DIRECTED[i].kind;
      it.start_x = DIRECTED[i].sx;
      it.start_y = DIRECTED[i].sy;
      it.end_x = DIRECTED[i].ex;
      it.end_y = DIRECTED[i].ey;
      offer_beat(it, DIRECTED[i].lit, DIRECTED[i].want);
    end

    for (phase = 0; phase < 8; phase++) begin
      drain_block();
      case (phase / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_reg(CFG_LOWER_STEP, cfg_sets[phase][0]);
      write_reg(CFG_RAISE_STEP, cfg_sets[phase][1]);
      write_reg(CFG_COLS, cfg_sets[phase][2]);
      write_reg(CFG_ROWS, cfg_sets[phase][3]);
      // An index past the register list must change nothing.
      if (phase == 1) write_reg(CFG_ROWS + 8'd4, 16'hffff);
      if (phase == 0) hold_request = 1;
      for (int n = 0; n < 144; n++) begin
        // Sender pause until every result is back.
        if (phase == 6 && n == 70) begin
          push <= 1'b0;
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        offer_beat(random_item(), 1'b0, '0);
      end
    end

    // Wind down once nothing is expected any more.
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/orup_pkg.sv
src/orup_front.sv
src/orup_queue.sv
src/orup_back.sv
src/occupancy_ray_update.sv
verif/occupancy_ray_update_test.sv
